// ===== design/lsf_pkg.sv =====
// Shared types, codes and arithmetic helpers for the lidar scan store.
package lsf_pkg;

	// Default sizing handed to the top-level parameters
	localparam int DEPTH_DEF       = 8;
	localparam int ANGLE_SPAN_DEF  = 180;
	localparam int MAX_SAMPLES_DEF = 2048;

	// Fixed widths of the datapath
	localparam int IDX_W = 12;
	localparam int CMP_W = 13;
	localparam logic [3:0] RES_RESET = 4'd10;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_HOLD
	} ctrl_state_t;

	typedef struct packed {
		logic [15:0] distance;
		logic        last_sample;
		status_t     status;
	} result_t;

	// Clamp the resolution register into its usable range
	function automatic logic [3:0] eff_res(input logic [3:0] r);
		logic [3:0] e;
		e = r;
		if (r == 4'd0) begin
			e = 4'd1;
		end else if (r > 4'd10) begin
			e = 4'd10;
		end
		return e;
	endfunction

	// ceil(2^16 / d); exact floor quotient for any 12-bit dividend
	function automatic logic [16:0] recip(input logic [3:0] d);
		logic [16:0] rv;
		case (d)
			4'd1: rv = 17'd65536;
			4'd2: rv = 17'd32768;
			4'd3: rv = 17'd21846;
			4'd4: rv = 17'd16384;
			4'd5: rv = 17'd13108;
			4'd6: rv = 17'd10923;
			4'd7: rv = 17'd9363;
			4'd8: rv = 17'd8192;
			4'd9: rv = 17'd7282;
			default: rv = 17'd6554;
		endcase
		return rv;
	endfunction

	// floor(x / d) for d in 1..10 by reciprocal multiplication
	function automatic logic [IDX_W-1:0] div_res(input logic [IDX_W-1:0] x,
			input logic [3:0] d);
		logic [28:0] prod;
		prod = 29'(x) * 29'(recip(d));
		return prod[27:16];
	endfunction

endpackage

// ===== design/lsf_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module lsf_ram #(
	parameter int WORDS = 2,
	parameter int WIDTH = 1,
	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [WORDS];

	// Write and read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/lsf_ctrl.sv =====
// Slot pointers, sample and slot-length RAMs, and the push/pop/read sequencer.
module lsf_ctrl #(
	parameter int DEPTH       = lsf_pkg::DEPTH_DEF,
	parameter int ANGLE_SPAN  = lsf_pkg::ANGLE_SPAN_DEF,
	parameter int MAX_SAMPLES = lsf_pkg::MAX_SAMPLES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [3:0]       res,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       op,
	input  logic [15:0]      sample_mm,
	input  logic             end_of_scan,
	input  logic [7:0]       angle_deg,
	output logic             rslt_valid,
	input  logic             rslt_ready,
	output lsf_pkg::result_t rslt
);

	import lsf_pkg::*;

	localparam int SLOT_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int HELD_W    = $clog2(DEPTH + 1);
	localparam int LEN_W     = $clog2(MAX_SAMPLES + 1);
	localparam int OFF_W     = $clog2(MAX_SAMPLES);
	localparam int MEM_WORDS = DEPTH * MAX_SAMPLES;
	localparam int ADDR_W    = $clog2(MEM_WORDS);
	localparam int SPAN10    = ANGLE_SPAN * 10;

	ctrl_state_t state_q, state_d;
	logic [SLOT_W-1:0] oldest_q, oldest_d, next_q, next_d;
	logic [HELD_W-1:0] held_q, held_d;
	logic [LEN_W-1:0]  wo_q, wo_d, ro_q, ro_d;

	logic             pop_s1, empty_s1;
	logic [IDX_W-1:0] idx_s1;
	result_t          hold_q;
	logic             hold_load;

	op_t              op_in;
	logic [3:0]       res_e;
	logic [CMP_W-1:0] len_raw, len_now;
	logic [IDX_W-1:0] ang10, idx_now;
	logic [SLOT_W-1:0] oldest_inc, next_inc, newest;
	logic              held_full, evict, wo_room;
	logic [LEN_W-1:0]  wo_fill;

	logic              scan_we, scan_re, meta_we, meta_re;
	logic [ADDR_W-1:0] scan_waddr, scan_raddr;
	logic [15:0]       scan_rdata;
	logic [SLOT_W-1:0] meta_raddr;
	logic [2*LEN_W-1:0] meta_rdata;
	logic [LEN_W-1:0]  meta_len, meta_fill;
	result_t           look_rslt;

	assign op_in = op_t'(op);
	assign res_e = eff_res(res);

	// Scan length in force and the sample index of a distance read
	assign len_raw = CMP_W'(div_res(IDX_W'(SPAN10), res_e)) + CMP_W'(1);
	assign len_now = (len_raw > CMP_W'(MAX_SAMPLES)) ? CMP_W'(MAX_SAMPLES) : len_raw;
	assign ang10   = {1'b0, angle_deg, 3'b000} + {3'b000, angle_deg, 1'b0};
	assign idx_now = div_res(ang10, res_e);

	// Slot pointer arithmetic, modulo DEPTH
	assign oldest_inc = (oldest_q == SLOT_W'(DEPTH - 1)) ? '0 : oldest_q + 1'b1;
	assign next_inc   = (next_q == SLOT_W'(DEPTH - 1)) ? '0 : next_q + 1'b1;
	assign newest     = (next_q == '0) ? SLOT_W'(DEPTH - 1) : next_q - 1'b1;

	assign held_full = (held_q == HELD_W'(DEPTH));
	assign evict     = (wo_q == '0) && held_full;
	assign wo_room   = CMP_W'(wo_q) < len_now;
	assign wo_fill   = wo_room ? wo_q + 1'b1 : wo_q;

	// Sample RAM addressing: slot base plus offset
	assign scan_waddr = ADDR_W'(next_q) * ADDR_W'(MAX_SAMPLES) + ADDR_W'(wo_q[OFF_W-1:0]);
	always_comb begin
		if (op_in == OP_POP) begin
			scan_raddr = ADDR_W'(oldest_q) * ADDR_W'(MAX_SAMPLES)
				+ ADDR_W'(ro_q[OFF_W-1:0]);
			meta_raddr = oldest_q;
		end else begin
			scan_raddr = ADDR_W'(newest) * ADDR_W'(MAX_SAMPLES)
				+ ADDR_W'(idx_now[OFF_W-1:0]);
			meta_raddr = newest;
		end
	end

	lsf_ram #(
		.WORDS(MEM_WORDS),
		.WIDTH(16)
	) u_scan_ram (
		.clk  (clk),
		.we   (scan_we),
		.waddr(scan_waddr),
		.wdata(sample_mm),
		.re   (scan_re),
		.raddr(scan_raddr),
		.rdata(scan_rdata)
	);

	// Per-slot committed length and count of samples actually written
	lsf_ram #(
		.WORDS(DEPTH),
		.WIDTH(2 * LEN_W)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(next_q),
		.wdata({LEN_W'(len_now), wo_fill}),
		.re   (meta_re),
		.raddr(meta_raddr),
		.rdata(meta_rdata)
	);

	assign meta_len  = meta_rdata[2*LEN_W-1:LEN_W];
	assign meta_fill = meta_rdata[LEN_W-1:0];

	// Build the result from the RAM read; unwritten tail samples read as zero
	always_comb begin
		look_rslt.distance    = '0;
		look_rslt.last_sample = 1'b0;
		look_rslt.status      = STAT_OK;
		if (empty_s1) begin
			look_rslt.status = STAT_EMPTY;
		end else if (pop_s1) begin
			look_rslt.distance    = (ro_q < meta_fill) ? scan_rdata : '0;
			look_rslt.last_sample = (CMP_W'(ro_q) + CMP_W'(1)) >= CMP_W'(meta_len);
		end else if (CMP_W'(idx_s1) >= CMP_W'(meta_len)) begin
			look_rslt.status = STAT_RANGE;
		end else begin
			look_rslt.distance = (CMP_W'(idx_s1) < CMP_W'(meta_fill)) ? scan_rdata : '0;
		end
	end

	// Next state, pointer updates and RAM strobes
	always_comb begin
		state_d   = state_q;
		oldest_d  = oldest_q;
		next_d    = next_q;
		held_d    = held_q;
		wo_d      = wo_q;
		ro_d      = ro_q;
		in_ready  = 1'b0;
		scan_we   = 1'b0;
		scan_re   = 1'b0;
		meta_we   = 1'b0;
		meta_re   = 1'b0;
		rslt_valid = 1'b0;
		rslt      = hold_q;
		hold_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (op_in) inside
						OP_PUSH: begin
							// Evict the oldest scan when a new scan starts on a full store
							if (evict) begin
								oldest_d = oldest_inc;
								ro_d     = '0;
							end
							scan_we = wo_room;
							if (end_of_scan) begin
								meta_we = 1'b1;
								next_d  = next_inc;
								wo_d    = '0;
							end else begin
								wo_d = wo_fill;
							end
							held_d = held_q + HELD_W'(end_of_scan) - HELD_W'(evict);
						end
						OP_POP, OP_READ: begin
							scan_re = 1'b1;
							meta_re = 1'b1;
							state_d = S_LOOKUP;
						end
						OP_CLEAR: begin
							oldest_d = '0;
							next_d   = '0;
							held_d   = '0;
							wo_d     = '0;
							ro_d     = '0;
						end
					endcase
				end
			end
			S_LOOKUP: begin
				rslt_valid = 1'b1;
				rslt       = look_rslt;
				// Advance the pop, dropping the scan after its last sample
				if (pop_s1 && !empty_s1) begin
					if (look_rslt.last_sample) begin
						oldest_d = oldest_inc;
						held_d   = held_q - 1'b1;
						ro_d     = '0;
					end else begin
						ro_d = ro_q + 1'b1;
					end
				end
				if (rslt_ready) begin
					state_d = S_IDLE;
				end else begin
					hold_load = 1'b1;
					state_d   = S_HOLD;
				end
			end
			S_HOLD: begin
				rslt_valid = 1'b1;
				if (rslt_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			oldest_q <= '0;
			next_q   <= '0;
			held_q   <= '0;
			wo_q     <= '0;
			ro_q     <= '0;
		end else begin
			state_q  <= state_d;
			oldest_q <= oldest_d;
			next_q   <= next_d;
			held_q   <= held_d;
			wo_q     <= wo_d;
			ro_q     <= ro_d;
		end
	end

	// Lookup stage payload and stalled result
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			pop_s1   <= (op_in == OP_POP);
			empty_s1 <= (held_q == '0);
			idx_s1   <= idx_now;
		end
		if (hold_load) begin
			hold_q <= look_rslt;
		end
	end

endmodule

// ===== design/lidar_scan_fifo.sv =====
// Push and clear update the store as they are accepted; a push streams one
// sample per cycle while no pop or read is pending. Pop and distance read do
// a synchronous read of the sample and slot-length RAMs, then form the result
// into the output register. While a result waits, pushes and clears pass and
// one pop or read is parked, then all input stalls. Reset empties the store,
// sets resolution to 10 and clears pointers and offsets, not the sample RAM.
module lidar_scan_fifo #(
	parameter int DEPTH       = lsf_pkg::DEPTH_DEF,
	parameter int ANGLE_SPAN  = lsf_pkg::ANGLE_SPAN_DEF,
	parameter int MAX_SAMPLES = lsf_pkg::MAX_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [15:0] sample_mm,
	input  logic        end_of_scan,
	input  logic [7:0]  angle_deg,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] distance_mm,
	output logic        last_sample,
	output logic [1:0]  status
);

	import lsf_pkg::*;

	logic [3:0] res_q;
	logic       rslt_valid, rslt_ready;
	result_t    rslt;
	logic       out_valid_q;
	result_t    out_q;

	// Resolution register, written on a config transfer
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= RES_RESET;
		end else if (cfg_valid) begin
			res_q <= cfg_data;
		end
	end

	lsf_ctrl #(
		.DEPTH(DEPTH),
		.ANGLE_SPAN(ANGLE_SPAN),
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.res        (res_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.sample_mm  (sample_mm),
		.end_of_scan(end_of_scan),
		.angle_deg  (angle_deg),
		.rslt_valid (rslt_valid),
		.rslt_ready (rslt_ready),
		.rslt       (rslt)
	);

	// Output register: load when empty or its transfer completes
	assign rslt_ready = !out_valid_q || out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rslt_ready) begin
			out_valid_q <= rslt_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (rslt_ready && rslt_valid) begin
			out_q <= rslt;
		end
	end

	assign out_valid   = out_valid_q;
	assign distance_mm = out_q.distance;
	assign last_sample = out_q.last_sample;
	assign status      = out_q.status;

endmodule
